// ===== rtl/core/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32I subset execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

  // Data memory size in 32-bit words and its index width.
  localparam int unsigned DMEM_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

  // Opcodes (bits 6:0) and the exact ebreak encoding.
  localparam logic [6:0] OP_LUI   = 7'h37;
  localparam logic [6:0] OP_AUIPC = 7'h17;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_IMM   = 7'h13;
  localparam logic [6:0] OP_JAL   = 7'h6F;
  localparam logic [6:0] OP_JALR  = 7'h67;

  localparam logic [2:0] F3_WORD  = 3'd2;
  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_JALR  = 3'd0;

  localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;

  // Register that holds the exit code.
  localparam logic [4:0] REG_A0 = 5'd10;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_START_PC  = 1'b0,
    CFG_DATA_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EBREAK  = 3'd1,
    ST_INVALID = 3'd2,
    ST_BADADDR = 3'd3,
    ST_HALTED  = 3'd4
  } status_e;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic [31:0]        npc;
    status_e            status;
    logic               we;
    logic [4:0]         rd;
    logic [31:0]        val;
    logic [31:0]        exit_code;
    logic               is_load;
    logic               is_store;
    logic               halt;
    logic [DMEM_AW-1:0] mem_idx;
  } exec_res_t;

endpackage

// ===== rtl/core/rvx_exec.sv =====
// ----------------------------------------------------------------------------
// rvx_exec
// Decode and execute of one instruction: immediates, adds, data address
// check and the next program counter.
// ----------------------------------------------------------------------------
module rvx_exec (
  input  logic               [31:0] instr_i,
  input  logic               [31:0] pc_i,
  input  logic                      halted_i,
  input  logic               [31:0] rs1_val_i,
  input  logic               [31:0] a0_val_i,
  input  logic               [31:0] data_base_i,
  output rvx_pkg::exec_res_t        res_o
);
  import rvx_pkg::*;

  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] pc_plus4;
  logic [31:0] mem_off;
  logic        addr_ok;
  logic        wr;
  logic [31:0] val;
  logic [31:0] jalr_sum;

  assign opcode   = instr_i[6:0];
  assign funct3   = instr_i[14:12];
  assign rd       = instr_i[11:7];
  assign imm_i    = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s    = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_u    = {instr_i[31:12], 12'b0};
  assign imm_j    = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                     instr_i[30:21], 1'b0};
  assign pc_plus4 = pc_i + 32'd4;
  assign jalr_sum = rs1_val_i + imm_i;

  // Offset from the start of data memory, in one three-input add.
  assign mem_off = rs1_val_i + ((opcode == OP_STORE) ? imm_s : imm_i) - data_base_i;
  assign addr_ok = (mem_off[1:0] == 2'b00) && (mem_off[31:2] < 30'(DMEM_WORDS));

  always_comb begin
    res_o           = '0;
    res_o.npc       = pc_plus4;
    res_o.status    = ST_OK;
    res_o.mem_idx   = mem_off[DMEM_AW+1:2];
    wr              = 1'b0;
    val             = '0;
    priority if (halted_i) begin
      res_o.status = ST_HALTED;
      res_o.npc    = pc_i;
    end else if (opcode == OP_LUI) begin
      wr  = 1'b1;
      val = imm_u;
    end else if (opcode == OP_LOAD && funct3 == F3_WORD) begin
      if (addr_ok) begin
        wr            = 1'b1;
        res_o.is_load = 1'b1;
      end else begin
        res_o.status = ST_BADADDR;
      end
    end else if (opcode == OP_STORE && funct3 == F3_WORD) begin
      if (addr_ok) begin
        res_o.is_store = 1'b1;
      end else begin
        res_o.status = ST_BADADDR;
      end
    end else if (opcode == OP_IMM && funct3 == F3_ADDI) begin
      wr  = 1'b1;
      val = rs1_val_i + imm_i;
    end else if (opcode == OP_AUIPC) begin
      wr  = 1'b1;
      val = pc_i + imm_u;
    end else if (opcode == OP_JAL) begin
      wr        = 1'b1;
      val       = pc_plus4;
      res_o.npc = pc_i + imm_j;
    end else if (opcode == OP_JALR && funct3 == F3_JALR) begin
      wr        = 1'b1;
      val       = pc_plus4;
      res_o.npc = {jalr_sum[31:1], 1'b0};
    end else if (instr_i == INSTR_EBREAK) begin
      res_o.status    = ST_EBREAK;
      res_o.exit_code = a0_val_i;
      res_o.halt      = 1'b1;
      res_o.npc       = pc_i;
    end else begin
      res_o.status = ST_INVALID;
      res_o.halt   = 1'b1;
      res_o.npc    = pc_i;
    end

    // A write to x0 is dropped and reported as no write.
    if (wr && rd != 5'd0) begin
      res_o.we  = 1'b1;
      res_o.rd  = rd;
      res_o.val = val;
    end else begin
      res_o.is_load = 1'b0;
    end
  end

endmodule

// ===== rtl/core/rv32i_subset_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit_core
// Executes lui, auipc, addi, lw, sw, jal, jalr and ebreak, one instruction
// word per item, with its own register file and data memory.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one instruction word per item, fetched at the
//   program counter reported as next_pc of the previous result. The master
//   stream returns one result per item: exec_pc, next_pc, status, the
//   register write and the exit code.
//   An item is held in the execute stage, then in the output register.
//   One item is accepted per cycle unless the receiver stalls; register
//   writes go back in the cycle after execute and are forwarded, so
//   dependent instructions do not wait.
//   After reset the data memory is cleared, one word a cycle, over all
//   DMEM_WORDS (1024) words; tready stays low until that pass is done.
//   Configuration writes are taken at any time; writing start_pc also
//   loads the program counter.
//   When the receiver stalls, the output register holds its result, the
//   execute stage holds the next item, and tready drops.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Config write port
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  // Instruction stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,  // [31:0] instruction
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [143:0] m_axis_tdata_o   // [31:0] exec_pc, [63:32] next_pc,
                                        // [66:64] status, [67] write_enable,
                                        // [72:68] write_index,
                                        // [104:73] write_value,
                                        // [136:105] exit_code, rest zero
);
  import rvx_pkg::*;

  // Configuration and architectural state
  logic [31:0]        data_base_q;
  logic [31:0]        pc_q;
  logic               halted_q;
  logic [31:0]        a0_q;

  // Data memory clearing pass
  logic               clr_busy_q;
  logic [DMEM_AW-1:0] clr_cnt_q;

  // Register file memory with one valid bit per entry
  logic [31:0]        rf_mem [32];
  logic [31:0]        rf_vld_q;
  logic [31:0]        rf_rd1_q;
  logic [31:0]        rf_rd2_q;
  logic               rd1_vld_q;
  logic               rd2_vld_q;

  // Execute stage
  logic               s1_valid_q;
  logic [31:0]        s1_instr_q;
  logic               byp1_q;
  logic               byp2_q;
  logic [31:0]        op1_q;
  logic [31:0]        op2_q;

  // Write-back stage
  logic               wb_valid_q;
  logic [4:0]         wb_rd_q;
  logic [31:0]        wb_val_q;
  logic               wb_load_q;
  logic [31:0]        wb_value;

  // Data memory
  logic [31:0]        dmem [DMEM_WORDS];
  logic [31:0]        dm_rdata_q;

  // Output register
  logic               out_vld_q;
  logic [31:0]        out_pc_q;
  logic [31:0]        out_npc_q;
  status_e            out_status_q;
  logic               out_we_q;
  logic [4:0]         out_rd_q;
  logic [31:0]        out_val_q;
  logic [31:0]        out_exit_q;
  logic               out_load_q;
  logic [31:0]        out_wval;

  logic               in_fire;
  logic               s1_fire;
  logic [4:0]         in_rs1;
  logic [4:0]         in_rs2;
  logic [4:0]         s1_rs1;
  logic [4:0]         s1_rs2;
  logic               wb_hit1;
  logic               wb_hit2;
  logic [31:0]        rs1_val;
  logic [31:0]        rs2_val;
  logic [31:0]        a0_val;
  exec_res_t          res;

  assign s1_fire         = s1_valid_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_rs1 = s_axis_tdata_i[19:15];
  assign in_rs2 = s_axis_tdata_i[24:20];
  assign s1_rs1 = s1_instr_q[19:15];
  assign s1_rs2 = s1_instr_q[24:20];

  // A load's value comes straight from the data memory read register.
  assign wb_value = wb_load_q ? dm_rdata_q : wb_val_q;
  assign wb_hit1  = wb_valid_q && (wb_rd_q == s1_rs1);
  assign wb_hit2  = wb_valid_q && (wb_rd_q == s1_rs2);

  // Youngest older write first, then a captured bypass, then the file.
  assign rs1_val = wb_hit1 ? wb_value : byp1_q ? op1_q : (rd1_vld_q ? rf_rd1_q : '0);
  assign rs2_val = wb_hit2 ? wb_value : byp2_q ? op2_q : (rd2_vld_q ? rf_rd2_q : '0);
  assign a0_val  = (wb_valid_q && wb_rd_q == REG_A0) ? wb_value : a0_q;

  rvx_exec u_exec (
    .instr_i     (s1_instr_q),
    .pc_i        (pc_q),
    .halted_i    (halted_q),
    .rs1_val_i   (rs1_val),
    .a0_val_i    (a0_val),
    .data_base_i (data_base_q),
    .res_o       (res)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q <= 32'h8000_0000;
      pc_q        <= 32'h8000_0000;
      halted_q    <= 1'b0;
      a0_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      rf_vld_q    <= '0;
      rd1_vld_q   <= 1'b0;
      rd2_vld_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      byp1_q      <= 1'b0;
      byp2_q      <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + DMEM_AW'(1);
        if (clr_cnt_q == DMEM_AW'(DMEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_START_PC:  pc_q        <= cfg_wdata_i;
          CFG_DATA_BASE: data_base_q <= cfg_wdata_i;
          default: ;
        endcase
      end else if (s1_fire) begin
        pc_q <= res.npc;
      end

      if (s1_fire && res.halt) begin
        halted_q <= 1'b1;
      end

      if (wb_valid_q) begin
        rf_vld_q[wb_rd_q] <= 1'b1;
        if (wb_rd_q == REG_A0) begin
          a0_q <= wb_value;
        end
      end

      if (in_fire) begin
        s1_valid_q <= 1'b1;
        rd1_vld_q  <= rf_vld_q[in_rs1];
        rd2_vld_q  <= rf_vld_q[in_rs2];
        byp1_q     <= wb_valid_q && (wb_rd_q == in_rs1);
        byp2_q     <= wb_valid_q && (wb_rd_q == in_rs2);
      end else begin
        if (s1_fire) begin
          s1_valid_q <= 1'b0;
        end
        // A stalled item keeps up with writes that land in the file.
        if (wb_hit1) begin
          byp1_q <= 1'b1;
        end
        if (wb_hit2) begin
          byp2_q <= 1'b1;
        end
      end

      wb_valid_q <= s1_fire && res.we;

      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_instr_q <= s_axis_tdata_i;
      op1_q      <= wb_value;
      op2_q      <= wb_value;
    end else begin
      if (wb_hit1) begin
        op1_q <= wb_value;
      end
      if (wb_hit2) begin
        op2_q <= wb_value;
      end
    end

    if (s1_fire) begin
      wb_rd_q      <= res.rd;
      wb_val_q     <= res.val;
      wb_load_q    <= res.is_load;
      out_pc_q     <= pc_q;
      out_npc_q    <= res.npc;
      out_status_q <= res.status;
      out_we_q     <= res.we;
      out_rd_q     <= res.rd;
      out_val_q    <= res.val;
      out_exit_q   <= res.exit_code;
      out_load_q   <= res.is_load;
    end
  end

  // Register file: one write port, two registered reads.
  always_ff @(posedge clk_i) begin
    if (wb_valid_q) begin
      rf_mem[wb_rd_q] <= wb_value;
    end
    if (in_fire) begin
      rf_rd1_q <= rf_mem[in_rs1];
      rf_rd2_q <= rf_mem[in_rs2];
    end
  end

  // Data memory: one write port, one registered read.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dmem[clr_cnt_q] <= '0;
    end else if (s1_fire && res.is_store) begin
      dmem[res.mem_idx] <= rs2_val;
    end
    if (s1_fire && res.is_load) begin
      dm_rdata_q <= dmem[res.mem_idx];
    end
  end

  assign out_wval        = out_load_q ? dm_rdata_q : out_val_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_exit_q, out_wval, out_rd_q, out_we_q,
                            out_status_q, out_npc_q, out_pc_q};

  // Assertions
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !s_axis_tready_o)
    else $error("item accepted during data memory clear");

  a_wb_never_x0 : assert property (
    @(posedge clk_i) disable iff (!rst_ni) wb_valid_q |-> (wb_rd_q != 5'd0))
    else $error("write-back to x0");

  a_out_write_index : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_we_q) |-> (out_rd_q == 5'd0 && out_wval == 32'd0))
    else $error("write fields set without a write");

  a_halt_holds_pc : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q == ST_EBREAK || out_status_q == ST_INVALID ||
                   out_status_q == ST_HALTED)) |-> (out_npc_q == out_pc_q))
    else $error("program counter moved on a halt");

  a_halted_reports : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && halted_q) |=> (out_status_q == ST_HALTED && !out_we_q))
    else $error("halted core executed an instruction");

endmodule

// ===== dv/tb_rv32i_subset_execute_unit_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32i_subset_execute_unit_core
// Self-checking bench for the RV32I subset execute unit. An in-bench model of
// the register file, data memory, program counter and halt flag predicts
// every result; directed instructions, then address-aware random programs,
// run under several base settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_rv32i_subset_execute_unit_core;
  import rvx_pkg::*;

  // One result item, laid out as on m_axis_tdata_o (lowest field last here).
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] exit_code;
    logic [31:0] write_value;
    logic [4:0]  write_index;
    logic        write_enable;
    status_e     status;
    logic [31:0] next_pc;
    logic [31:0] exec_pc;
  } exec_result_t;

  // Tracks the architectural state of the core and the results it owes.
  class rv_exec_tracker;
    logic [31:0]  gpr [32];
    logic [31:0]  dmem [DMEM_WORDS];
    logic [31:0]  pc;
    logic [31:0]  start_pc;
    logic [31:0]  data_base;
    bit           halted;
    exec_result_t pending_results [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  executed;
    int unsigned  loads;
    int unsigned  stores;
    int unsigned  bad_addr;
    int unsigned  after_halt;
    int unsigned  configs;
    logic [31:0]  exit_seen;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      start_pc  = 32'h8000_0000;
      data_base = 32'h8000_0000;
      pc        = start_pc;
      halted    = 1'b0;
    endfunction

    function void set_config(cfg_idx_e idx, logic [31:0] value);
      if (idx == CFG_START_PC) begin
        start_pc = value;
        pc       = value;
        configs++;
      end else begin
        data_base = value;
      end
    endfunction

    function bit word_slot(logic [31:0] addr, output int unsigned slot);
      logic [31:0] off;
      off  = addr - data_base;
      slot = off[31:2];
      return (off[1:0] == 2'b00) && (off[31:2] < DMEM_WORDS);
    endfunction

    function void note_instruction(logic [31:0] w);
      exec_result_t e;
      logic [31:0]  rs1v;
      logic [31:0]  rs2v;
      logic [31:0]  imm_i;
      logic [31:0]  imm_s;
      logic [31:0]  imm_u;
      logic [31:0]  imm_j;
      logic [31:0]  val;
      logic [4:0]   rd;
      bit           wr;
      int unsigned  slot;
      e         = '0;
      e.exec_pc = pc;
      e.next_pc = pc + 32'd4;
      e.status  = ST_OK;
      rd        = w[11:7];
      rs1v      = gpr[w[19:15]];
      rs2v      = gpr[w[24:20]];
      imm_i     = {{20{w[31]}}, w[31:20]};
      imm_s     = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_u     = {w[31:12], 12'b0};
      imm_j     = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      wr        = 1'b0;
      val       = '0;
      executed++;
      if (halted) begin
        e.status  = ST_HALTED;
        e.next_pc = pc;
        after_halt++;
      end else if (w[6:0] == OP_LUI) begin
        wr  = 1'b1;
        val = imm_u;
      end else if (w[6:0] == OP_LOAD && w[14:12] == F3_WORD) begin
        loads++;
        if (word_slot(rs1v + imm_i, slot)) begin
          wr  = 1'b1;
          val = dmem[slot];
        end else begin
          e.status = ST_BADADDR;
          bad_addr++;
        end
      end else if (w[6:0] == OP_STORE && w[14:12] == F3_WORD) begin
        stores++;
        if (word_slot(rs1v + imm_s, slot)) begin
          dmem[slot] = rs2v;
        end else begin
          e.status = ST_BADADDR;
          bad_addr++;
        end
      end else if (w[6:0] == OP_IMM && w[14:12] == F3_ADDI) begin
        wr  = 1'b1;
        val = rs1v + imm_i;
      end else if (w[6:0] == OP_AUIPC) begin
        wr  = 1'b1;
        val = pc + imm_u;
      end else if (w[6:0] == OP_JAL) begin
        wr        = 1'b1;
        val       = pc + 32'd4;
        e.next_pc = pc + imm_j;
      end else if (w[6:0] == OP_JALR && w[14:12] == F3_JALR) begin
        wr        = 1'b1;
        val       = pc + 32'd4;
        e.next_pc = (rs1v + imm_i) & ~32'd1;
      end else if (w == INSTR_EBREAK) begin
        e.status    = ST_EBREAK;
        e.exit_code = gpr[REG_A0];
        exit_seen   = gpr[REG_A0];
        e.next_pc   = pc;
        halted      = 1'b1;
      end else begin
        e.status  = ST_INVALID;
        e.next_pc = pc;
        halted    = 1'b1;
      end
      // A write to x0 is computed but dropped.
      if (wr && rd != 5'd0) begin
        gpr[rd]        = val;
        e.write_enable = 1'b1;
        e.write_index  = rd;
        e.write_value  = val;
      end
      pc = e.next_pc;
      pending_results.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [143:0] data);
      exec_result_t got;
      exec_result_t want;
      got = exec_result_t'(data);
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no instruction outstanding: expected none, actual %h",
                 $time, data);
        return;
      end
      want = pending_results.pop_front();
      compare("exec_pc", want.exec_pc, got.exec_pc);
      compare("next_pc", want.next_pc, got.next_pc);
      compare("status", 32'(want.status), 32'(got.status));
      compare("write_enable", 32'(want.write_enable), 32'(got.write_enable));
      compare("write_index", 32'(want.write_index), 32'(got.write_index));
      compare("write_value", want.write_value, got.write_value);
      compare("exit_code", want.exit_code, got.exit_code);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni          = 1'b0;
  logic         cfg_we_i        = 1'b0;
  logic [0:0]   cfg_idx_i       = '0;
  logic [31:0]  cfg_wdata_i     = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i  = '0;  // [31:0] instruction
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;        // [31:0] exec_pc, [63:32] next_pc,
                                       // [66:64] status, [67] write_enable,
                                       // [72:68] write_index,
                                       // [104:73] write_value,
                                       // [136:105] exit_code, rest zero

  rv_exec_tracker tracker;
  bit             tx_idle_on      = 1'b0;
  logic           rx_idle_on      = 1'b0;
  logic           long_hold_go    = 1'b0;
  bit             long_hold_taken = 1'b0;
  int unsigned    hold_left       = 0;

  rv32i_subset_execute_unit_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check every accepted item, then choose tready for the next cycle.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_result(m_axis_tdata_o);
    end
    if (long_hold_go && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left       = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(rx_idle_on && $urandom_range(99) < 30);
    end
  end

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [4:0] rs1, logic [4:0] rs2, logic [11:0] imm);
    return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_u(logic [6:0] op, logic [4:0] rd, logic [19:0] imm);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // Half the picks come from a few low registers so that back-to-back
  // instructions depend on each other often.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(1) == 1) return 5'($urandom_range(7));
    return 5'($urandom_range(31));
  endfunction

  // Leaves tvalid high after acceptance; whoever lets time pass lowers it.
  task automatic send_instr(logic [31:0] instr);
    if (tx_idle_on && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= instr;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_instruction(instr);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  task automatic load_config(logic [31:0] pc0, logic [31:0] base);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_START_PC;
    cfg_wdata_i <= pc0;
    @(posedge clk_i);
    tracker.set_config(CFG_START_PC, pc0);
    cfg_idx_i   <= CFG_DATA_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    tracker.set_config(CFG_DATA_BASE, base);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly aims lw/sw at real data words; reuses any register that is close
  // enough to the target as the base, otherwise sets one up with lui.
  task automatic send_mem_op(bit is_store);
    logic [31:0] target;
    logic [31:0] diff;
    logic [31:0] hi;
    logic [4:0]  base_reg;
    logic [4:0]  other_reg;
    int unsigned first;
    bit          found;
    if ($urandom_range(9) < 8) begin
      if ($urandom_range(3) == 0) begin
        target = tracker.data_base + 4 * $urandom_range(DMEM_WORDS - 1);
      end else begin
        target = tracker.data_base + 4 * $urandom_range(15);
      end
    end else begin
      case ($urandom_range(3))
        0:       target = tracker.data_base + 4 * $urandom_range(15) + $urandom_range(1, 3);
        1:       target = tracker.data_base + 4 * (DMEM_WORDS + $urandom_range(15));
        2:       target = tracker.data_base - 4 * $urandom_range(1, 16);
        default: target = $urandom;
      endcase
    end
    found    = 1'b0;
    first    = $urandom_range(31);
    base_reg = '0;
    for (int k = 0; k < 32 && !found; k++) begin
      base_reg = 5'(first + k);
      diff     = target - tracker.gpr[base_reg];
      found    = (diff[31:11] == '0) || (diff[31:11] == '1);
    end
    if (!found) begin
      base_reg = 5'($urandom_range(1, 31));
      hi       = target + 32'h800;
      send_instr(enc_u(OP_LUI, base_reg, hi[31:12]));
      diff = target - {hi[31:12], 12'b0};
    end
    other_reg = pick_reg();
    if (is_store) begin
      send_instr(enc_s(base_reg, other_reg, diff[11:0]));
    end else begin
      send_instr(enc_i(OP_LOAD, F3_WORD, other_reg, base_reg, diff[11:0]));
    end
  endtask

  task automatic run_random(int unsigned count);
    logic [31:0] r;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      r    = $urandom;
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_instr({r[31:12], pick_reg(), OP_LUI});
      end else if (pick < 22) begin
        send_instr({r[31:12], pick_reg(), OP_AUIPC});
      end else if (pick < 42) begin
        send_instr({r[31:20], pick_reg(), F3_ADDI, pick_reg(), OP_IMM});
      end else if (pick < 60) begin
        send_mem_op(1'b0);
      end else if (pick < 76) begin
        send_mem_op(1'b1);
      end else if (pick < 82) begin
        // Load or store with arbitrary fields; the address is usually bad.
        if (r[0]) send_instr({r[31:15], F3_WORD, r[11:7], OP_LOAD});
        else      send_instr({r[31:15], F3_WORD, r[11:7], OP_STORE});
      end else if (pick < 90) begin
        send_instr({r[31:12], pick_reg(), OP_JAL});
      end else begin
        send_instr({r[31:20], pick_reg(), F3_JALR, pick_reg(), OP_JALR});
      end
    end
  endtask

  task automatic run_directed();
    send_instr(enc_u(OP_LUI, 5'd1, 20'hFFFFF));
    send_instr(enc_u(OP_LUI, 5'd0, 20'h12345));                // x0 destination
    send_instr(enc_i(OP_IMM, F3_ADDI, 5'd2, 5'd0, 12'h800));   // most negative
    send_instr(enc_i(OP_IMM, F3_ADDI, 5'd3, 5'd0, 12'h7FF));   // most positive
    send_instr(enc_i(OP_IMM, F3_ADDI, 5'd4, 5'd1, 12'hFFF));
    send_instr(enc_u(OP_AUIPC, 5'd5, 20'h80000));
    send_instr(enc_u(OP_LUI, 5'd6, 20'h80000));
    send_instr(enc_s(5'd6, 5'd3, 12'h000));                     // first data word
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd7, 5'd6, 12'h000));
    send_instr(enc_u(OP_LUI, 5'd8, 20'h80001));
    send_instr(enc_s(5'd8, 5'd2, 12'hFFC));                     // last data word
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd9, 5'd8, 12'hFFC));
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd9, 5'd8, 12'h000));   // one past the end
    send_instr(enc_s(5'd6, 5'd2, 12'h002));                     // misaligned
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd11, 5'd6, 12'hFFC));  // below the base
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd0, 5'd6, 12'h000));
    send_instr(enc_j(5'd1, 21'h1FFFFC));
    send_instr(enc_j(5'd0, 21'h0FFFFE));
    send_instr(enc_i(OP_JALR, F3_JALR, 5'd12, 5'd3, 12'h000));  // odd target
    send_instr(enc_i(OP_JALR, F3_JALR, 5'd13, 5'd13, 12'h004)); // link reg is source
    send_instr(enc_i(OP_IMM, F3_ADDI, 5'd14, 5'd14, 12'h001));
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd6, 5'd6, 12'h000));
  endtask

  // Sets a0, halts on ebreak, then offers words that must all be ignored.
  task automatic run_halt();
    logic [31:0] r;
    r = $urandom;
    send_instr(enc_u(OP_LUI, REG_A0, r[31:12]));
    send_instr(enc_i(OP_IMM, F3_ADDI, REG_A0, REG_A0, r[11:0]));
    send_instr(INSTR_EBREAK);
    send_instr(INSTR_EBREAK);
    send_instr($urandom & 32'hFFFF_FFFC);
    send_instr(enc_i(OP_LOAD, 3'd0, 5'd1, 5'd0, 12'h000));
    send_instr(enc_u(OP_LUI, 5'd1, 20'hABCDE));
    for (int i = 0; i < 6; i++) begin
      send_instr($urandom);
    end
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    wait_drained();
    load_config(32'h0000_0000, 32'h0000_0000);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    run_random(150);

    // Data region wraps past the top of the address space; no idling here.
    wait_drained();
    load_config(32'hFFFF_FFFC, 32'hFFFF_F800);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    run_random(150);

    // The receiver holds off while the sender keeps offering items.
    wait_drained();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    rx_idle_on   <= 1'b1;
    long_hold_go <= 1'b1;
    run_random(60);
    tx_idle_on = 1'b1;
    run_random(90);

    wait_drained();
    load_config($urandom, $urandom);
    run_random(150);

    wait_drained();
    load_config(32'h8000_0000, 32'h8000_0000);
    run_random(100);
    run_halt();

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d instructions over %0d base settings: %0d loads, %0d stores, %0d bad addresses.",
             tracker.executed, tracker.configs, tracker.loads, tracker.stores,
             tracker.bad_addr);
    $display("Checked %0d results; halted with a0 = %h and ignored %0d later items.",
             tracker.checked, tracker.exit_seen, tracker.after_halt);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
